// ----- design/iphg_pkg.sv -----
// Shared types and constants for the IPv4 header generator.
// Used by the interfaces, the front and back stages, the queue and the top level.
// No dependencies.
package iphg_pkg;

    // Field widths of the request and result beats.
    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int LEN_W   = 16;
    localparam int WORD_W  = 16;
    localparam int MTU_W   = 16;

    // Fixed header contents.
    localparam logic [WORD_W-1:0] VERSION_WORD = 16'h4500;
    localparam logic [WORD_W-1:0] IP_ID        = 16'd2333;
    localparam logic [7:0]        IP_TTL       = 8'd233;
    localparam logic [LEN_W:0]    HDR_BYTES    = 17'd20;
    localparam int                HDR_WORDS    = 10;
    localparam logic [MTU_W-1:0]  MTU_RESET    = 16'd1500;

    // Constant words of the header folded into one checksum addend.
    localparam int HDR_CONST_SUM = int'(VERSION_WORD) + int'(IP_ID) + (int'(IP_TTL) << 8);

    // Width of the partial checksum (five addends) and the full sum (seven addends).
    localparam int PSUM_W = 19;
    localparam int SUM_W  = 20;

    // Word position within a header.
    localparam int POS_W = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_ADDRESS    = 1'b0,
        CFG_MAX_TRANSFER_UNIT = 1'b1
    } cfg_reg_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic               length_error;
        logic [LEN_W-1:0]   total_length;
        logic [PROTO_W-1:0] protocol_number;
        logic [ADDR_W-1:0]  dest_address;
        logic [PSUM_W-1:0]  partial_sum;
    } hdr_job_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/iphg_ifs.sv -----
// Valid/ready channel interfaces for the request and the header word beats.
// Depends on iphg_pkg for the field widths.
interface iphg_req_if
    import iphg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  dest_address;
    logic [PROTO_W-1:0] protocol_number;
    logic [LEN_W-1:0]   payload_length;

    modport source (output valid, dest_address, protocol_number, payload_length,
                    input ready);
    modport sink   (input valid, dest_address, protocol_number, payload_length,
                    output ready);
endinterface

interface iphg_hdr_if
    import iphg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] header_word;
    logic              is_last;
    logic              length_error;

    modport source (output valid, header_word, is_last, length_error, input ready);
    modport sink   (input valid, header_word, is_last, length_error, output ready);
endinterface

// ----- design/ipv4_header_generator.sv -----
// IPv4 header generator: a header's first word is offered once its request beat has
// passed the queue slot and the back stage's job register; a header takes ten output
// beats, an error one beat. The word-per-beat output sets the sustained throughput.
// Reset (rst_n, asynchronous, active low) empties the queue, idles the output and
// sets the source address to zero and the MTU to 1500. No clearing pass is needed.
module ipv4_header_generator
    import iphg_pkg::*;
#(
    parameter int QueueDepth = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    iphg_req_if.sink               req,
    iphg_hdr_if.source             hdr,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    logic [ADDR_W-1:0] source_address_reg;
    logic [MTU_W-1:0]  max_transfer_unit_reg;

    logic          push;
    logic          pop;
    hdr_job_t      push_job;
    hdr_job_t      head_job;
    queue_status_t status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_address_reg    <= '0;
            max_transfer_unit_reg <= MTU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SOURCE_ADDRESS:    source_address_reg    <= cfg_data;
                CFG_MAX_TRANSFER_UNIT: max_transfer_unit_reg <= cfg_data[MTU_W-1:0];
                default:               source_address_reg    <= source_address_reg;
            endcase
        end
    end

    iphg_front u_front (
        .req               (req),
        .max_transfer_unit (max_transfer_unit_reg),
        .status            (status),
        .push              (push),
        .push_job          (push_job)
    );

    iphg_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (status)
    );

    iphg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr            (hdr),
        .source_address (source_address_reg),
        .status         (status),
        .head_job       (head_job),
        .pop            (pop)
    );

endmodule

// ----- design/iphg_queue.sv -----
// Small register queue of classified requests between the front and the back.
// Depends on iphg_pkg for the job and status types.
module iphg_queue
    import iphg_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hdr_job_t      push_job,
    input  logic          pop,
    output hdr_job_t      head_job,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hdr_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill-count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

// ----- design/iphg_front.sv -----
// Front stage: accepts send requests, checks the length against the MTU and
// starts the header checksum. Depends on iphg_pkg and iphg_req_if.
module iphg_front
    import iphg_pkg::*;
(
    iphg_req_if.sink         req,
    input  logic [MTU_W-1:0] max_transfer_unit,
    input  queue_status_t    status,
    output logic             push,
    output hdr_job_t         push_job
);

    logic [LEN_W:0] total_wide;

    // A request is taken whenever the queue has room.
    assign req.ready = !status.full;
    assign push      = req.valid && !status.full;

    // Total length cannot wrap here: it is kept one bit wider than a length.
    assign total_wide = {1'b0, req.payload_length} + HDR_BYTES;

    // Classify the request and sum the words known so far.
    always_comb
    begin
        push_job.length_error    = total_wide > {1'b0, max_transfer_unit};
        push_job.total_length    = total_wide[LEN_W-1:0];
        push_job.protocol_number = req.protocol_number;
        push_job.dest_address    = req.dest_address;
        push_job.partial_sum     = PSUM_W'(HDR_CONST_SUM)
                                 + PSUM_W'(total_wide[LEN_W-1:0])
                                 + PSUM_W'(req.protocol_number)
                                 + PSUM_W'(req.dest_address[31:16])
                                 + PSUM_W'(req.dest_address[15:0]);
    end

endmodule

// ----- design/iphg_back.sv -----
// Back stage: takes one classified request at a time, finishes the checksum
// and sends the header one word per beat. Depends on iphg_pkg and iphg_hdr_if.
module iphg_back
    import iphg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    iphg_hdr_if.source        hdr,
    input  logic [ADDR_W-1:0] source_address,
    input  queue_status_t     status,
    input  hdr_job_t          head_job,
    output logic              pop
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_WORDS - 1);

    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    hdr_job_t          job_reg;
    logic [WORD_W-1:0] csum_reg;

    logic              beat_done;
    logic              last_beat;
    logic [SUM_W-1:0]  full_sum;
    logic [16:0]       fold_once;
    logic [WORD_W-1:0] fold_twice;
    logic [WORD_W-1:0] word_sel;

    // The current job ends on its error beat or its tenth word.
    assign last_beat = job_reg.length_error || (pos_reg == LAST_POS);
    assign beat_done = hdr.valid && hdr.ready;
    assign pop       = !status.empty && (!busy_reg || (beat_done && last_beat));

    // Finish the ones'-complement checksum with the source address words.
    always_comb
    begin
        full_sum   = SUM_W'(head_job.partial_sum)
                   + SUM_W'(source_address[31:16])
                   + SUM_W'(source_address[15:0]);
        fold_once  = 17'(full_sum[15:0]) + 17'(full_sum[SUM_W-1:16]);
        fold_twice = fold_once[15:0] + 16'(fold_once[16]);
    end

    // Word position and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
        else if (beat_done && last_beat)
        begin
            busy_next = 1'b0;
        end
        else if (beat_done)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    // Job and checksum are loaded together when a job is taken.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head_job;
            csum_reg <= ~fold_twice;
        end
    end

    // Select the header word for the current position.
    always_comb
    begin
        case (pos_reg)
            4'd0:    word_sel = VERSION_WORD;
            4'd1:    word_sel = job_reg.total_length;
            4'd2:    word_sel = IP_ID;
            4'd3:    word_sel = '0;
            4'd4:    word_sel = {IP_TTL, job_reg.protocol_number};
            4'd5:    word_sel = csum_reg;
            4'd6:    word_sel = source_address[31:16];
            4'd7:    word_sel = source_address[15:0];
            4'd8:    word_sel = job_reg.dest_address[31:16];
            4'd9:    word_sel = job_reg.dest_address[15:0];
            default: word_sel = '0;
        endcase
    end

    assign hdr.valid        = busy_reg;
    assign hdr.header_word  = job_reg.length_error ? '0 : word_sel;
    assign hdr.is_last      = last_beat;
    assign hdr.length_error = job_reg.length_error;

endmodule

// ----- design/iphg_checker.sv -----
// Port-level checks for the IPv4 header generator output channel.
// Depends on iphg_pkg; bound to ipv4_header_generator at the end of the file.
module iphg_checker
    import iphg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] header_word,
    input logic              is_last,
    input logic              length_error
);

    logic first_reg;

    // Tracks whether the next output beat opens a new result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            first_reg <= is_last;
        end
    end

    // An error beat is a single zero word that closes the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> is_last && (header_word == '0))
        else $error("error beat is not a last zero word");

    // Inside a header the next word follows at once and no error appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !is_last |=> out_valid && !length_error)
        else $error("header broken off before its last word");

    // A header always opens with the version word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_reg && !length_error |-> header_word == VERSION_WORD)
        else $error("header does not start with the version word");

    // A stalled beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(header_word) && $stable(is_last))
        else $error("stalled output beat changed");

endmodule

bind ipv4_header_generator iphg_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (hdr.valid),
    .out_ready    (hdr.ready),
    .header_word  (hdr.header_word),
    .is_last      (hdr.is_last),
    .length_error (hdr.length_error)
);

// ----- dv/iphg_header_checker.sv -----
`timescale 1ns / 1ps
// Checker for the IPv4 header generator: watches the request, header and register ports,
// predicts every header beat and compares it with what the block sends.
// Depends on iphg_pkg and the channel interfaces in iphg_ifs.sv.
module iphg_header_checker
    import iphg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    iphg_req_if                    req,
    iphg_hdr_if                    hdr,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    output int unsigned            fault_count,
    output int unsigned            beats_pending
);

    // One predicted header beat.
    typedef struct packed {
        logic [WORD_W-1:0] header_word;
        logic              is_last;
        logic              length_error;
    } hdr_beat_t;

    // Shadow copies of the registers and the beats still owed by the block.
    logic [ADDR_W-1:0] src_address;
    logic [MTU_W-1:0]  mtu_bytes;
    hdr_beat_t         words_due[$];
    int unsigned       beats_seen;

    initial
    begin
        fault_count   = 0;
        beats_pending = 0;
        beats_seen    = 0;
    end

    // Builds the header for one request, or the single error beat, and queues it.
    task automatic queue_header_words(input logic [ADDR_W-1:0] dest,
                                      input logic [PROTO_W-1:0] proto,
                                      input logic [LEN_W-1:0] plen);
        logic [LEN_W:0]    total;
        logic [WORD_W-1:0] words [HDR_WORDS];
        logic [31:0]       sum;
        hdr_beat_t         beat;
        total = {1'b0, plen} + HDR_BYTES;
        if (total > {1'b0, mtu_bytes})
        begin
            beat = '{header_word: '0, is_last: 1'b1, length_error: 1'b1};
            words_due.push_back(beat);
        end
        else
        begin
            words[0] = VERSION_WORD;
            words[1] = total[LEN_W-1:0];
            words[2] = IP_ID;
            words[3] = '0;
            words[4] = {IP_TTL, proto};
            words[5] = '0;
            words[6] = src_address[31:16];
            words[7] = src_address[15:0];
            words[8] = dest[31:16];
            words[9] = dest[15:0];
            // Ones'-complement sum with the checksum field taken as zero.
            sum = '0;
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                sum += 32'(words[i]);
            end
            while (sum[31:16] != 0)
            begin
                sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
            end
            words[5] = ~sum[15:0];
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                beat = '{header_word: words[i], is_last: (i == HDR_WORDS - 1),
                         length_error: 1'b0};
                words_due.push_back(beat);
            end
        end
    endtask

    // Counts a failure and reports the first few in detail.
    task automatic log_fault(input string what, input hdr_beat_t want);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("header beat %0d: %s: expected word %h last %b err %b,",
                     beats_seen, what, want.header_word, want.is_last, want.length_error);
            $display("    got word %h last %b err %b",
                     hdr.header_word, hdr.is_last, hdr.length_error);
        end
    endtask

    // Sample all ports at the clock edge: header beats, requests, then register writes,
    // so a request sees the register values that the block used at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        hdr_beat_t want;
        if (!rst_n)
        begin
            src_address = '0;
            mtu_bytes   = MTU_RESET;
            words_due.delete();
        end
        else
        begin
            if (hdr.valid && hdr.ready)
            begin
                if (words_due.size() == 0)
                begin
                    log_fault("no beat expected", '0);
                end
                else
                begin
                    want = words_due.pop_front();
                    if (hdr.header_word !== want.header_word || hdr.is_last !== want.is_last ||
                        hdr.length_error !== want.length_error)
                    begin
                        log_fault("mismatch", want);
                    end
                end
                beats_seen++;
            end
            if (req.valid && req.ready)
            begin
                queue_header_words(req.dest_address, req.protocol_number, req.payload_length);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SOURCE_ADDRESS)
                begin
                    src_address = cfg_data;
                end
                else if (cfg_index == CFG_MAX_TRANSFER_UNIT)
                begin
                    mtu_bytes = cfg_data[MTU_W-1:0];
                end
            end
        end
        beats_pending = words_due.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the IPv4 header generator: clock, reset, request and register stimulus,
// receiver back-pressure and the verdict. Depends on iphg_pkg, iphg_ifs.sv and the checker.
module tb;
    import iphg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SUBPHASE_REQS = 58;
    localparam int DRAIN_CYCLES  = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    logic [31:0] cfg_data;
    int unsigned fault_count;
    int unsigned beats_pending;
    int unsigned cycle_count;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;

    iphg_req_if req_ch ();
    iphg_hdr_if hdr_ch ();

    ipv4_header_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .hdr       (hdr_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iphg_header_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .hdr           (hdr_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fault_count   (fault_count),
        .beats_pending (beats_pending)
    );

    // Clock with a 4 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs counted here when asked for.
    initial
    begin : receiver
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        hdr_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                hdr_ch.ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES - 1;
                hdr_ch.ready <= 1'b0;
            end
            else
            begin
                hdr_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one request beat and returns at the edge where it is accepted.
    task automatic send_request(input logic [31:0] dest, input logic [7:0] proto,
                                input logic [15:0] plen);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        req_ch.valid           <= 1'b1;
        req_ch.dest_address    <= dest;
        req_ch.protocol_number <= proto;
        req_ch.payload_length  <= plen;
        do @(negedge clk); while (!req_ch.ready);
        @(posedge clk);
    endtask

    // Drops valid and waits until every predicted beat has come out.
    task automatic drain;
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (beats_pending != 0);
    endtask

    // Writes both registers on consecutive cycles while the block is idle.
    task automatic set_config(input logic [31:0] src, input logic [15:0] mtu);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE_ADDRESS;
        cfg_data  <= src;
        @(posedge clk);
        cfg_index <= CFG_MAX_TRANSFER_UNIT;
        cfg_data  <= {16'h0, mtu};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Payload length: mostly fitting the MTU, some at the boundary, some anywhere.
    function automatic logic [15:0] pick_payload(input logic [15:0] mtu);
        int room;
        int v;
        room = int'(mtu) - 20;
        if (room < 0)
        begin
            return 16'($urandom);
        end
        case ($urandom_range(3))
            0, 1: v = $urandom_range(room);
            2: v = room - 2 + $urandom_range(4);
            default: v = $urandom_range(65535);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return 16'(v);
    endfunction

    // Main stimulus: reset, directed requests, then random phases of idling and stalls.
    initial
    begin : stimulus
        logic [15:0] mtu;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_SOURCE_ADDRESS;
        cfg_data               <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.dest_address    <= '0;
        req_ch.protocol_number <= '0;
        req_ch.payload_length  <= '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_requests   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: source 0, MTU 1500.
        // The destination is chosen so the folded sum is all ones and the checksum is zero.
        send_request(32'h0000_C8CD, 8'h00, 16'd0);
        send_request(32'h0000_0000, 8'h00, 16'd0);
        send_request(32'hFFFF_FFFF, 8'hFF, 16'd1480);
        send_request(32'h1234_5678, 8'd1, 16'd1481);
        send_request(32'h8765_4321, 8'd17, 16'd65535);
        send_request(32'hC0A8_0001, 8'd6, 16'd512);
        send_request(32'h0A00_0002, 8'd17, 16'd8);
        drain();

        // Widest MTU: the largest total length fits, one byte more does not.
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        send_request(32'h7F00_0001, 8'd17, 16'd65515);
        send_request(32'h7F00_0001, 8'd17, 16'd65516);
        send_request(32'hFFFF_FFFF, 8'hFF, 16'd65535);
        send_request(32'hFFFF_FFFF, 8'hFF, 16'd0);
        drain();

        // Smallest legal MTU: only an empty payload fits.
        set_config(32'hA5A5_5A5A, 16'd20);
        send_request(32'h5A5A_A5A5, 8'h80, 16'd0);
        send_request(32'h5A5A_A5A5, 8'h7F, 16'd1);
        drain();

        // MTU below the header size rejects every request.
        set_config(32'h0102_0304, 16'd0);
        send_request(32'h0506_0708, 8'd1, 16'd0);
        drain();
        set_config(32'h0102_0304, 16'd19);
        send_request(32'h0506_0708, 8'd1, 16'd0);
        drain();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 23 : 0;
            recv_stall_pct <= (phase == 2) ? 88 : (phase == 3) ? 23 : 0;
            for (int sub = 0; sub < 2; sub++)
            begin
                case ((phase * 2 + sub) % 4)
                    0: mtu = 16'($urandom_range(20, 65535));
                    1: mtu = 16'hFFFF;
                    2: mtu = 16'd1500;
                    default: mtu = 16'($urandom_range(20, 2000));
                endcase
                set_config($urandom, mtu);
                // Long receiver hold-off so the block fills up and stalls requests.
                if (phase == 0 && sub == 0)
                begin
                    hold_requests <= hold_requests + 1;
                end
                for (int n = 0; n < SUBPHASE_REQS; n++)
                begin
                    send_request($urandom, 8'($urandom), pick_payload(mtu));
                end
                drain();
            end
        end

        // Let any stray beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
